/* design/keypad_four_function_calculator_assert.svh */
// ----------------------------------------------------------------------------
// Calculator assertion macros
// Concurrent checks on the clock, with reset as the disable condition.
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_ASSERT_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define KFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kfc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define KFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kfc: next-cycle check failed");

`else

`define KFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define KFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/kfc_pkg.sv */
// ----------------------------------------------------------------------------
// Calculator package
// Key codes, operation codes, defaults and the arithmetic unit request word.
// ----------------------------------------------------------------------------
package kfc_pkg;

    // Default arithmetic width
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int unsigned KEY_W     = 4;
    localparam int unsigned DIGITS_W  = 4;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned DISPLAY_W = 32;

    // Digit limit after reset
    localparam logic [DIGITS_W-1:0] MAX_DIGITS_RST = 4'd15;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_0 = 4'd0;
    localparam logic [KEY_W-1:0] KEY_DIGIT_9 = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CLEAR   = 4'd10;
    localparam logic [KEY_W-1:0] KEY_ADD     = 4'd11;
    localparam logic [KEY_W-1:0] KEY_SUB     = 4'd12;
    localparam logic [KEY_W-1:0] KEY_MUL     = 4'd13;
    localparam logic [KEY_W-1:0] KEY_DIV     = 4'd14;
    localparam logic [KEY_W-1:0] KEY_EQUALS  = 4'd15;

    // Pending operation codes
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_NONE = 3'd0;
    localparam t_op OP_ADD  = 3'd1;
    localparam t_op OP_SUB  = 3'd2;
    localparam t_op OP_MUL  = 3'd3;
    localparam t_op OP_DIV  = 3'd4;

    // Request from the key sequencer to the arithmetic unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

endpackage

/* design/kfc_alu.sv */
// ----------------------------------------------------------------------------
// Calculator arithmetic unit
// Sequenced arithmetic, step by step: add and subtract in one step,
// shift-add multiply and restoring divide at one bit per step. Division
// works on magnitudes, truncates toward zero, and a zero divisor gives 0.
// ----------------------------------------------------------------------------
`include "keypad_four_function_calculator_assert.svh"

module kfc_alu #(
    parameter int unsigned WIDTH = kfc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kfc_pkg::t_alu_req   i_req,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output logic                o_done,
    output logic [WIDTH-1:0]    o_result
);
    import kfc_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    // Sequencer states
    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_ABS  = 3'd1;
    localparam logic [2:0] A_LOOP = 3'd2;
    localparam logic [2:0] A_SIGN = 3'd3;
    localparam logic [2:0] A_DONE = 3'd4;

    logic [2:0]       r_state, n_state;
    t_op              r_op, n_op;
    logic [WIDTH-1:0] r_a, n_a;      // multiplicand / dividend, then quotient
    logic [WIDTH-1:0] r_b, n_b;      // multiplier / divisor
    logic [WIDTH-1:0] r_acc, n_acc;  // product / remainder / result
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic             r_zero, n_zero;

    logic [WIDTH:0]   w_trial;

    // Restoring divide trial subtraction
    assign w_trial = {r_acc, r_a[WIDTH-1]} - {1'b0, r_b};

    // Step sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_zero  = r_zero;

        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_a     = i_a;
                    n_b     = i_b;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_neg   = i_a[WIDTH-1] ^ i_b[WIDTH-1];
                    n_zero  = (i_b == '0);
                    n_state = (i_req.op == OP_DIV) ? A_ABS : A_LOOP;
                end
            end
            A_ABS: begin
                n_a     = r_a[WIDTH-1] ? (WIDTH'(0) - r_a) : r_a;
                n_b     = r_b[WIDTH-1] ? (WIDTH'(0) - r_b) : r_b;
                n_state = A_LOOP;
            end
            A_LOOP: begin
                unique case (r_op)
                    OP_ADD: begin
                        n_acc   = r_a + r_b;
                        n_state = A_DONE;
                    end
                    OP_SUB: begin
                        n_acc   = r_a - r_b;
                        n_state = A_DONE;
                    end
                    OP_MUL: begin
                        if (r_b[0]) begin
                            n_acc = r_acc + r_a;
                        end
                        n_a     = {r_a[WIDTH-2:0], 1'b0};
                        n_b     = {1'b0, r_b[WIDTH-1:1]};
                        n_cnt   = r_cnt + 1'b1;
                        n_state = (r_cnt == CNT_LAST) ? A_DONE : A_LOOP;
                    end
                    OP_DIV: begin
                        if (!w_trial[WIDTH]) begin
                            n_acc = w_trial[WIDTH-1:0];
                        end else begin
                            n_acc = {r_acc[WIDTH-2:0], r_a[WIDTH-1]};
                        end
                        n_a     = {r_a[WIDTH-2:0], ~w_trial[WIDTH]};
                        n_cnt   = r_cnt + 1'b1;
                        n_state = (r_cnt == CNT_LAST) ? A_SIGN : A_LOOP;
                    end
                    default: begin
                        n_acc   = '0;
                        n_state = A_DONE;
                    end
                endcase
            end
            A_SIGN: begin
                if (r_zero) begin
                    n_acc = '0;
                end else if (r_neg) begin
                    n_acc = WIDTH'(0) - r_a;
                end else begin
                    n_acc = r_a;
                end
                n_state = A_DONE;
            end
            A_DONE: begin
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_done   = (r_state == A_DONE);
    assign o_result = r_acc;

    // Checks
    `KFC_ASSERT_IMPLY(a_start_when_idle, i_clk, i_rst_n, i_req.start, r_state == A_IDLE)
    `KFC_ASSERT_NEXT(a_done_then_idle, i_clk, i_rst_n, o_done, r_state == A_IDLE)
    `KFC_ASSERT_IMPLY(a_sign_only_div, i_clk, i_rst_n, r_state == A_SIGN, r_op == OP_DIV)

endmodule

/* design/keypad_four_function_calculator.sv */
// ----------------------------------------------------------------------------
// Keypad four-function calculator
// Takes one key word at a time and answers with one display word per key.
// ----------------------------------------------------------------------------
// When a key is accepted, the sequencer goes to its show state, which loads
// the display word into the output register; this holds for digit, clear and
// operator keys and for equals with nothing pending. Equals with a pending
// operation first runs through the shared arithmetic unit: add and subtract
// take one step, multiply and divide run the one-bit-per-cycle shift-add and
// restoring divide loops, and divide adds a magnitude step before and a sign
// step after its loop. The key channel is not ready while a key is being
// worked on; it reopens as the display word moves into the output register.
// If the previous display word is still waiting for the consumer, the new
// word is held back and the key channel stays closed until the consumer
// takes it. The max_digits register may be written at any time and holds 15
// after reset; clear leaves it untouched.
// ----------------------------------------------------------------------------
`include "keypad_four_function_calculator_assert.svh"

module keypad_four_function_calculator #(
    parameter int unsigned VALUE_WIDTH = kfc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Key channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [kfc_pkg::KEY_W-1:0]              i_key,
    // Display channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [kfc_pkg::DISPLAY_W-1:0]   o_display_value,
    output logic [kfc_pkg::DIGITS_W-1:0]           o_entry_digits,
    output logic [kfc_pkg::OP_W-1:0]               o_pending_op,
    // Configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [kfc_pkg::DIGITS_W-1:0]           i_cfg_data
);
    import kfc_pkg::*;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_SHOW = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_entry, n_entry;
    logic [DIGITS_W-1:0]    r_count, n_count;
    logic [VALUE_WIDTH-1:0] r_first, n_first;
    t_op                    r_operation, n_operation;
    logic                   r_fresh, n_fresh;
    logic [DIGITS_W-1:0]    r_max_digits;

    logic                   r_out_valid, n_out_valid;
    logic [DISPLAY_W-1:0]   r_display, n_display;
    logic [DIGITS_W-1:0]    r_digits_out, n_digits_out;
    t_op                    r_op_out, n_op_out;

    t_alu_req               w_alu_req;
    logic                   w_alu_done;
    logic [VALUE_WIDTH-1:0] w_alu_result;
    logic [VALUE_WIDTH-1:0] w_base_val;
    logic [DIGITS_W-1:0]    w_base_cnt;
    logic                   w_accept;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid & o_ready;
    assign o_cfg_ready = 1'b1;

    // Entry a digit builds on: a fresh entry starts from zero
    assign w_base_val = r_fresh ? '0 : r_entry;
    assign w_base_cnt = r_fresh ? '0 : r_count;

    // Key sequencer
    always_comb begin
        n_state      = r_state;
        n_entry      = r_entry;
        n_count      = r_count;
        n_first      = r_first;
        n_operation  = r_operation;
        n_fresh      = r_fresh;
        n_out_valid  = r_out_valid & ~i_ready;
        n_display    = r_display;
        n_digits_out = r_digits_out;
        n_op_out     = r_op_out;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = r_operation;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SHOW;
                    case (i_key) inside
                        [KEY_DIGIT_0:KEY_DIGIT_9]: begin
                            n_fresh = 1'b0;
                            if (w_base_cnt < r_max_digits) begin
                                // times ten as two shifts
                                n_entry = (w_base_val << 3) + (w_base_val << 1)
                                        + VALUE_WIDTH'(i_key);
                                n_count = w_base_cnt + 1'b1;
                            end else begin
                                n_entry = w_base_val;
                                n_count = w_base_cnt;
                            end
                        end
                        KEY_CLEAR: begin
                            n_entry     = '0;
                            n_count     = '0;
                            n_first     = '0;
                            n_operation = OP_NONE;
                            n_fresh     = 1'b1;
                        end
                        KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
                            n_first = r_entry;
                            n_fresh = 1'b1;
                            unique case (i_key)
                                KEY_ADD: n_operation = OP_ADD;
                                KEY_SUB: n_operation = OP_SUB;
                                KEY_MUL: n_operation = OP_MUL;
                                default: n_operation = OP_DIV;
                            endcase
                        end
                        default: begin
                            // equals: ignored with nothing pending
                            if (r_operation != OP_NONE) begin
                                w_alu_req.start = 1'b1;
                                n_state         = S_CALC;
                            end
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (w_alu_done) begin
                    n_entry     = w_alu_result;
                    n_count     = '0;
                    n_operation = OP_NONE;
                    n_fresh     = 1'b1;
                    n_state     = S_SHOW;
                end
            end
            S_SHOW: begin
                // load the display word once the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_display    = DISPLAY_W'(r_entry);
                    n_digits_out = r_count;
                    n_op_out     = r_operation;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Shared arithmetic unit
    kfc_alu #(
        .WIDTH (VALUE_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (r_first),
        .i_b      (r_entry),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    // Control and calculator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_entry      <= '0;
            r_count      <= '0;
            r_first      <= '0;
            r_operation  <= OP_NONE;
            r_fresh      <= 1'b1;
            r_max_digits <= MAX_DIGITS_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry     <= n_entry;
            r_count     <= n_count;
            r_first     <= n_first;
            r_operation <= n_operation;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_max_digits <= i_cfg_data;
            end
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        r_display    <= n_display;
        r_digits_out <= n_digits_out;
        r_op_out     <= n_op_out;
    end

    assign o_valid         = r_out_valid;
    assign o_display_value = $signed(r_display);
    assign o_entry_digits  = r_digits_out;
    assign o_pending_op    = r_op_out;

    // Checks
    `KFC_ASSERT_NEXT(a_busy_after_key, i_clk, i_rst_n, w_accept, !o_ready)
    `KFC_ASSERT_IMPLY(a_calc_has_op, i_clk, i_rst_n, r_state == S_CALC, r_operation != OP_NONE)
    `KFC_ASSERT_IMPLY(a_done_in_calc, i_clk, i_rst_n, w_alu_done, r_state == S_CALC)

endmodule
